// ===== rtl/tlfq_pkg.sv =====
// Shared types, codes and sizes of the three-level feedback queue scheduler.
package tlfq_pkg;

  localparam int PID_W           = 15;
  localparam int LVL_W           = 2;
  localparam int CNT_W           = 5;
  localparam int SLOT_COUNT      = 16;
  localparam int SLOT_W          = 4;
  localparam int FIFO_COUNT      = 3;
  localparam int LOWEST_LEVEL    = 2;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int LIMIT_RESET     = 5;

  typedef enum logic [1:0] {
    CMD_ADMIT     = 2'd0,
    CMD_DISPATCH  = 2'd1,
    CMD_TERMINATE = 2'd2,
    CMD_REQUEUE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SLOTS_FULL = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FIFO_FULL  = 3'd3,
    ST_UNKNOWN    = 3'd4,
    ST_BUSY       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FIFO0 = 2'd0,
    FIFO1 = 2'd1,
    FIFO2 = 2'd2
  } fifo_sel_t;

  typedef struct packed {
    cmd_t             command;
    logic [PID_W-1:0] proc_id;
    logic             interrupted;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [PID_W-1:0] picked_id;
    logic [LVL_W-1:0] picked_level;
    logic [CNT_W-1:0] active_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic match;
    logic find;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_search;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/tlfq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tlfq_ram #(
  parameter int WIDTH = tlfq_pkg::PID_W,
  parameter int DEPTH = 3 * tlfq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tlfq_ctrl.sv =====
// Sequencing state machine of the scheduler.
module tlfq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tlfq_pkg::dp_stat_t   stat,
  output tlfq_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_MATCH  = 5'b00100,
    S_FIND   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_search ? S_MATCH : S_RESULT;
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_FIND;
      end
      S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/tlfq_dp.sv =====
// Datapath of the scheduler: slot table, queue pointers, queue RAM and result register.
module tlfq_dp #(
  parameter int QUEUE_DEPTH = tlfq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tlfq_pkg::CNT_W-1:0]   cfg_data,
  input  tlfq_pkg::in_word_t           in_data,
  input  tlfq_pkg::ctrl_cmd_t          cmd,
  output tlfq_pkg::dp_stat_t           stat,
  input  logic                         out_stall,
  output logic                         out_valid,
  output tlfq_pkg::out_word_t          out_data
);

  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int SW        = CW + 1;
  localparam int RAM_DEPTH = 3 * QUEUE_DEPTH;
  localparam int AW        = $clog2(RAM_DEPTH);
  localparam int PID_W     = tlfq_pkg::PID_W;
  localparam int LVL_W     = tlfq_pkg::LVL_W;
  localparam int CNT_W     = tlfq_pkg::CNT_W;
  localparam int SLOTS     = tlfq_pkg::SLOT_COUNT;
  localparam int SLOT_W    = tlfq_pkg::SLOT_W;
  localparam int FIFOS     = tlfq_pkg::FIFO_COUNT;

  localparam logic [CW-1:0]    FULL_CNT  = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]    LAST_PTR  = PW'(QUEUE_DEPTH - 1);
  localparam logic [SW-1:0]    WRAP      = SW'(QUEUE_DEPTH);
  localparam logic [AW-1:0]    BASE1     = AW'(QUEUE_DEPTH);
  localparam logic [AW-1:0]    BASE2     = AW'(2 * QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] MAX_SLOTS = CNT_W'(SLOTS);
  localparam logic [LVL_W-1:0] LOW_LVL   = LVL_W'(tlfq_pkg::LOWEST_LEVEL);

  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [PW-1:0] ring_tail(input logic [PW-1:0] head,
                                             input logic [CW-1:0] cnt);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(cnt);
    if (sum >= WRAP) begin
      sum = sum - WRAP;
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] fifo_addr(input tlfq_pkg::fifo_sel_t sel,
                                             input logic [PW-1:0] ptr);
    logic [AW-1:0] a;
    case (sel)
      tlfq_pkg::FIFO0: a = AW'(ptr);
      tlfq_pkg::FIFO1: a = BASE1 + AW'(ptr);
      default:         a = BASE2 + AW'(ptr);
    endcase
    return a;
  endfunction

  logic [CNT_W-1:0]    slot_limit_r, slot_limit_nxt;
  tlfq_pkg::in_word_t  in_r, in_nxt;
  logic [PID_W-1:0]    key_r, key_nxt;
  logic [SLOTS-1:0]    match_r, match_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [PID_W-1:0]    spid_r [SLOTS];
  logic [PID_W-1:0]    spid_nxt [SLOTS];
  logic [LVL_W-1:0]    slvl_r [SLOTS];
  logic [LVL_W-1:0]    slvl_nxt [SLOTS];
  logic [CNT_W-1:0]    active_r, active_nxt;
  logic                outst_r, outst_nxt;
  logic [PW-1:0]       head_r [FIFOS];
  logic [PW-1:0]       head_nxt [FIFOS];
  logic [CW-1:0]       cnt_r [FIFOS];
  logic [CW-1:0]       cnt_nxt [FIFOS];
  tlfq_pkg::status_t   status_r, status_nxt;
  logic [PID_W-1:0]    picked_r, picked_nxt;
  logic [LVL_W-1:0]    plevel_r, plevel_nxt;
  logic                out_valid_r, out_valid_nxt;
  tlfq_pkg::out_word_t out_data_r, out_data_nxt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [PID_W-1:0]    ram_wdata, ram_rdata;

  logic [CNT_W-1:0]    limit_eff;
  logic                has_free;
  logic [SLOT_W-1:0]   free_idx;
  logic                any_queued;
  tlfq_pkg::fifo_sel_t pop_sel;
  logic                found;
  logic [SLOT_W-1:0]   hit_idx;
  logic [LVL_W-1:0]    lvl_cur, lvl_new;
  tlfq_pkg::fifo_sel_t push_sel;
  logic                is_dispatch;

  assign limit_eff   = (slot_limit_r > MAX_SLOTS) ? MAX_SLOTS : slot_limit_r;
  assign has_free    = |(~valid_r);
  assign free_idx    = first_set(~valid_r);
  assign any_queued  = (cnt_r[tlfq_pkg::FIFO0] != '0) || (cnt_r[tlfq_pkg::FIFO1] != '0)
                       || (cnt_r[tlfq_pkg::FIFO2] != '0);
  assign pop_sel     = (cnt_r[tlfq_pkg::FIFO0] != '0) ? tlfq_pkg::FIFO0 :
                       (cnt_r[tlfq_pkg::FIFO1] != '0) ? tlfq_pkg::FIFO1 : tlfq_pkg::FIFO2;
  assign found       = |match_r;
  assign hit_idx     = first_set(match_r);
  assign lvl_cur     = slvl_r[hit_idx];
  assign is_dispatch = (in_r.command == tlfq_pkg::CMD_DISPATCH);

  // An interrupted process keeps its level and returns to the top queue.
  always_comb begin
    if (in_r.interrupted) begin
      lvl_new  = lvl_cur;
      push_sel = tlfq_pkg::FIFO0;
    end else begin
      lvl_new  = (lvl_cur < LOW_LVL) ? lvl_cur + LVL_W'(1) : lvl_cur;
      push_sel = (lvl_new == LVL_W'(1)) ? tlfq_pkg::FIFO1 : tlfq_pkg::FIFO2;
    end
  end

  assign stat.need_search = (in_r.command != tlfq_pkg::CMD_ADMIT)
                            && !(is_dispatch && (outst_r || !any_queued));
  assign stat.out_free    = !out_valid_r || !out_stall;

  always_comb begin
    slot_limit_nxt = slot_limit_r;
    in_nxt         = in_r;
    key_nxt        = key_r;
    match_nxt      = match_r;
    valid_nxt      = valid_r;
    spid_nxt       = spid_r;
    slvl_nxt       = slvl_r;
    active_nxt     = active_r;
    outst_nxt      = outst_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    picked_nxt     = picked_r;
    plevel_nxt     = plevel_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = '0;
    ram_raddr      = '0;
    ram_wdata      = in_r.proc_id;

    if (cfg_we) begin
      slot_limit_nxt = cfg_data;
    end

    if (cmd.capture) begin
      in_nxt = in_data;
    end

    if (cmd.exec) begin
      status_nxt = tlfq_pkg::ST_OK;
      picked_nxt = '0;
      plevel_nxt = '0;
      case (in_r.command)
        tlfq_pkg::CMD_ADMIT: begin
          if ((active_r >= limit_eff) || !has_free) begin
            status_nxt = tlfq_pkg::ST_SLOTS_FULL;
          end else if (cnt_r[tlfq_pkg::FIFO0] == FULL_CNT) begin
            status_nxt = tlfq_pkg::ST_FIFO_FULL;
          end else begin
            ram_we                       = 1'b1;
            ram_waddr                    = fifo_addr(tlfq_pkg::FIFO0,
                                             ring_tail(head_r[tlfq_pkg::FIFO0],
                                                       cnt_r[tlfq_pkg::FIFO0]));
            cnt_nxt[tlfq_pkg::FIFO0]     = cnt_r[tlfq_pkg::FIFO0] + CW'(1);
            valid_nxt[free_idx]          = 1'b1;
            spid_nxt[free_idx]           = in_r.proc_id;
            slvl_nxt[free_idx]           = '0;
            active_nxt                   = active_r + CNT_W'(1);
          end
        end
        tlfq_pkg::CMD_DISPATCH: begin
          if (outst_r) begin
            status_nxt = tlfq_pkg::ST_BUSY;
          end else if (!any_queued) begin
            status_nxt = tlfq_pkg::ST_EMPTY;
          end else begin
            ram_re            = 1'b1;
            ram_raddr         = fifo_addr(pop_sel, head_r[pop_sel]);
            head_nxt[pop_sel] = ptr_inc(head_r[pop_sel]);
            cnt_nxt[pop_sel]  = cnt_r[pop_sel] - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.match) begin
      key_nxt = is_dispatch ? ram_rdata : in_r.proc_id;
      for (int i = 0; i < SLOTS; i++) begin
        match_nxt[i] = valid_r[i] && (spid_r[i] == key_nxt);
      end
    end

    if (cmd.find) begin
      if (!found) begin
        status_nxt = tlfq_pkg::ST_UNKNOWN;
      end else begin
        case (in_r.command)
          tlfq_pkg::CMD_DISPATCH: begin
            picked_nxt = key_r;
            plevel_nxt = lvl_cur;
            outst_nxt  = 1'b1;
          end
          tlfq_pkg::CMD_TERMINATE: begin
            valid_nxt[hit_idx] = 1'b0;
            if (active_r != '0) begin
              active_nxt = active_r - CNT_W'(1);
            end
            outst_nxt = 1'b0;
          end
          tlfq_pkg::CMD_REQUEUE: begin
            outst_nxt = 1'b0;
            if (cnt_r[push_sel] == FULL_CNT) begin
              status_nxt = tlfq_pkg::ST_FIFO_FULL;
            end else begin
              ram_we             = 1'b1;
              ram_waddr          = fifo_addr(push_sel,
                                     ring_tail(head_r[push_sel], cnt_r[push_sel]));
              cnt_nxt[push_sel]  = cnt_r[push_sel] + CW'(1);
              slvl_nxt[hit_idx]  = lvl_new;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd.load_out) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = status_r;
      out_data_nxt.picked_id    = picked_r;
      out_data_nxt.picked_level = plevel_r;
      out_data_nxt.active_count = active_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= CNT_W'(tlfq_pkg::LIMIT_RESET);
      valid_r      <= '0;
      active_r     <= '0;
      outst_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int f = 0; f < FIFOS; f++) begin
        head_r[f] <= '0;
        cnt_r[f]  <= '0;
      end
    end else begin
      slot_limit_r <= slot_limit_nxt;
      valid_r      <= valid_nxt;
      active_r     <= active_nxt;
      outst_r      <= outst_nxt;
      out_valid_r  <= out_valid_nxt;
      head_r       <= head_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    key_r      <= key_nxt;
    match_r    <= match_nxt;
    spid_r     <= spid_nxt;
    slvl_r     <= slvl_nxt;
    status_r   <= status_nxt;
    picked_r   <= picked_nxt;
    plevel_r   <= plevel_nxt;
    out_data_r <= out_data_nxt;
  end

  tlfq_ram #(
    .WIDTH (PID_W),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/three_level_feedback_queue_scheduler_unit.sv =====
// Top level of the three-level feedback queue scheduler.
//
// Each input word is one command: admit a new process at level 0, dispatch the
// next process (top queue first, then the middle, then the bottom), or report
// on the running process, either terminating it or requeueing it one level
// lower, at most to level 2 (or back to the top queue, level kept, if interrupted).
// Exactly one result word comes back per command, carrying a status code, the
// dispatched process id and its level, and the active count after the step.
// The block handles one command at a time: an admit, or a dispatch that is
// refused as busy or empty, passes through the execute and result states after
// capture; a dispatch that pops an entry and every report also pass through
// the match and find states, which cover the registered read of the queue RAM
// and the slot table search: the match state registers the sixteen identifier
// compares and the find state priority-encodes the hit.
// A command whose previous result is still stalled downstream waits in its
// last cycle until that result has been taken.
// The next word is accepted in the cycle after the result is loaded, even if
// that result is still stalled downstream. The three queues share one RAM of
// 3 * QUEUE_DEPTH entries; queue contents are only read after being written,
// so no clearing pass is needed after reset. The slot limit register may be
// written at any time through the configuration port, but only while the
// block is idle is the effect well defined; values above sixteen act as sixteen.
module three_level_feedback_queue_scheduler_unit #(
  parameter int QUEUE_DEPTH = tlfq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tlfq_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tlfq_pkg::out_word_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tlfq_pkg::CNT_W-1:0] cfg_data
);

  tlfq_pkg::ctrl_cmd_t cmd;
  tlfq_pkg::dp_stat_t  stat;

  // The configuration register is always ready to take a word.
  assign cfg_ready = 1'b1;

  tlfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlfq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // Once a word is accepted the block is busy with it in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again straight after an accept");

  // A new result only appears right after the block was busy.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a command in progress");

  // A non-zero picked id is only ever returned with an ok status and a real level.
  a_pick_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.picked_id != '0)) |->
      ((out_data.status == tlfq_pkg::ST_OK) && (out_data.picked_level != 2'd3)))
    else $error("picked id returned with a failing status or bad level");

  // The active count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.active_count <= 5'(tlfq_pkg::SLOT_COUNT)))
    else $error("active count beyond the slot table size");
`endif

endmodule

// ===== sim/three_level_feedback_queue_scheduler_unit_test.sv =====
// Self-checking testbench of the three-level feedback queue scheduler unit.
class mlfq_tracker;
  logic [tlfq_pkg::PID_W-1:0] ring_store [tlfq_pkg::FIFO_COUNT][tlfq_pkg::QUEUE_DEPTH_DEF];
  int unsigned                ring_head  [tlfq_pkg::FIFO_COUNT];
  int unsigned                ring_fill  [tlfq_pkg::FIFO_COUNT];
  bit                         slot_live  [tlfq_pkg::SLOT_COUNT];
  logic [tlfq_pkg::PID_W-1:0] slot_owner [tlfq_pkg::SLOT_COUNT];
  logic [tlfq_pkg::LVL_W-1:0] slot_lvl   [tlfq_pkg::SLOT_COUNT];
  int unsigned                live_total;
  bit                         awaiting_report;
  logic [tlfq_pkg::PID_W-1:0] running_pid;
  logic [tlfq_pkg::CNT_W-1:0] slot_limit;
  tlfq_pkg::out_word_t        due_replies[$];
  int unsigned                bad_replies;

  function new();
    foreach (ring_head[q]) begin
      ring_head[q] = 0;
      ring_fill[q] = 0;
    end
    foreach (slot_live[s]) slot_live[s] = 1'b0;
    live_total      = 0;
    awaiting_report = 1'b0;
    running_pid     = '0;
    slot_limit      = tlfq_pkg::CNT_W'(tlfq_pkg::LIMIT_RESET);
    bad_replies     = 0;
  endfunction

  function bit push_ring(int q, logic [tlfq_pkg::PID_W-1:0] v);
    if (ring_fill[q] >= tlfq_pkg::QUEUE_DEPTH_DEF) return 1'b0;
    ring_store[q][(ring_head[q] + ring_fill[q]) % tlfq_pkg::QUEUE_DEPTH_DEF] = v;
    ring_fill[q]++;
    return 1'b1;
  endfunction

  function bit pop_ring(int q, output logic [tlfq_pkg::PID_W-1:0] v);
    v = '0;
    if (ring_fill[q] == 0) return 1'b0;
    v = ring_store[q][ring_head[q]];
    ring_head[q] = (ring_head[q] + 1) % tlfq_pkg::QUEUE_DEPTH_DEF;
    ring_fill[q]--;
    return 1'b1;
  endfunction

  // Lowest valid slot holding the pid, or -1.
  function int owner_slot(logic [tlfq_pkg::PID_W-1:0] pid);
    for (int i = 0; i < tlfq_pkg::SLOT_COUNT; i++)
      if (slot_live[i] && slot_owner[i] == pid) return i;
    return -1;
  endfunction

  function tlfq_pkg::out_word_t predict_reply(tlfq_pkg::in_word_t w);
    tlfq_pkg::out_word_t        r;
    int                         cap;
    int                         s;
    bit                         popped;
    logic [tlfq_pkg::PID_W-1:0] got;
    logic [tlfq_pkg::LVL_W-1:0] lvl;
    tlfq_pkg::fifo_sel_t        dest;
    r = '0;
    r.status = tlfq_pkg::ST_OK;
    cap = (slot_limit > tlfq_pkg::SLOT_COUNT) ? tlfq_pkg::SLOT_COUNT : int'(slot_limit);
    case (w.command)
      tlfq_pkg::CMD_ADMIT: begin
        s = -1;
        for (int i = tlfq_pkg::SLOT_COUNT - 1; i >= 0; i--)
          if (!slot_live[i]) s = i;
        if (live_total >= cap || s < 0) begin
          r.status = tlfq_pkg::ST_SLOTS_FULL;
        end else if (!push_ring(int'(tlfq_pkg::FIFO0), w.proc_id)) begin
          r.status = tlfq_pkg::ST_FIFO_FULL;
        end else begin
          slot_live[s]  = 1'b1;
          slot_owner[s] = w.proc_id;
          slot_lvl[s]   = '0;
          live_total++;
        end
      end
      tlfq_pkg::CMD_DISPATCH: begin
        if (awaiting_report) begin
          r.status = tlfq_pkg::ST_BUSY;
        end else begin
          popped = pop_ring(int'(tlfq_pkg::FIFO0), got);
          if (!popped) popped = pop_ring(int'(tlfq_pkg::FIFO1), got);
          if (!popped) popped = pop_ring(int'(tlfq_pkg::FIFO2), got);
          if (!popped) begin
            r.status = tlfq_pkg::ST_EMPTY;
          end else begin
            s = owner_slot(got);
            if (s < 0) begin
              r.status = tlfq_pkg::ST_UNKNOWN;
            end else begin
              r.picked_id     = got;
              r.picked_level  = slot_lvl[s];
              awaiting_report = 1'b1;
              running_pid     = got;
            end
          end
        end
      end
      default: begin
        s = owner_slot(w.proc_id);
        if (s < 0) begin
          r.status = tlfq_pkg::ST_UNKNOWN;
        end else if (w.command == tlfq_pkg::CMD_TERMINATE) begin
          slot_live[s] = 1'b0;
          if (live_total > 0) live_total--;
          awaiting_report = 1'b0;
        end else begin
          lvl  = slot_lvl[s];
          dest = tlfq_pkg::FIFO0;
          if (!w.interrupted) begin
            if (lvl < tlfq_pkg::LOWEST_LEVEL) lvl = lvl + 1'b1;
            dest = (lvl == 1) ? tlfq_pkg::FIFO1 : tlfq_pkg::FIFO2;
          end
          if (push_ring(int'(dest), w.proc_id)) slot_lvl[s] = lvl;
          else r.status = tlfq_pkg::ST_FIFO_FULL;
          awaiting_report = 1'b0;
        end
      end
    endcase
    r.active_count = tlfq_pkg::CNT_W'(live_total);
    return r;
  endfunction

  function void note_command(tlfq_pkg::in_word_t w);
    due_replies.push_back(predict_reply(w));
  endfunction

  function void check_reply(tlfq_pkg::out_word_t got);
    tlfq_pkg::out_word_t want;
    if (due_replies.size() == 0) begin
      bad_replies++;
      if (bad_replies <= 10)
        $display("unexpected reply: status %0d id %0d level %0d count %0d",
                 got.status, got.picked_id, got.picked_level, got.active_count);
      return;
    end
    want = due_replies.pop_front();
    if (got.status !== want.status || got.picked_id !== want.picked_id ||
        got.picked_level !== want.picked_level ||
        got.active_count !== want.active_count) begin
      bad_replies++;
      if (bad_replies <= 10)
        $display("reply differs (status id level count): expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                 want.status, want.picked_id, want.picked_level, want.active_count,
                 got.status, got.picked_id, got.picked_level, got.active_count);
    end
  endfunction
endclass

module three_level_feedback_queue_scheduler_unit_test;

  // The slowest correct run stays well below this many cycles, even with the
  // long receiver hold-off and the heaviest idling.
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          POOL_SIZE   = 12;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  tlfq_pkg::in_word_t         in_data;
  logic                       out_valid;
  logic                       out_stall;
  tlfq_pkg::out_word_t        out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [tlfq_pkg::CNT_W-1:0] cfg_data;

  mlfq_tracker                sb;
  logic [tlfq_pkg::PID_W-1:0] pid_pool [POOL_SIZE];
  int                         send_idle_pct;
  int                         stall_pct;
  int                         hold_requests;
  int unsigned                cycles_run = 0;

  three_level_feedback_queue_scheduler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycles_run <= cycles_run + 1;

  // Watchdog: a run that has not finished by the limit has hung somewhere.
  initial begin
    wait (cycles_run >= CYCLE_LIMIT);
    $display("three_level_feedback_queue_scheduler_unit: mismatch");
    $finish;
  end

  // Both handshakes are observed at the rising edge. An accepted command word
  // is run through the predictor at once, so the expectation queue always
  // lies in acceptance order; a result word is compared with the oldest one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_command(in_data);
      if (out_valid && !out_stall) sb.check_reply(out_data);
    end
  end

  // Receiver. Stalls at random at the current rate, and on request holds the
  // output off for a long stretch so that the block backs up and stalls its
  // input. The hold is counted here, in cycles, independently of the sender.
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // A fresh pid, biased towards the two extremes of the field.
  function logic [tlfq_pkg::PID_W-1:0] fresh_pid();
    case ($urandom_range(7))
      0:       return tlfq_pkg::PID_W'(1);
      1:       return {tlfq_pkg::PID_W{1'b1}};
      default: return tlfq_pkg::PID_W'($urandom_range(32767, 1));
    endcase
  endfunction

  // Random words mostly follow the life of a process: admit from a small pool
  // of pids, dispatch, then report on the pid that is running. A few reports
  // name a random pid, which the block should not know.
  function tlfq_pkg::in_word_t next_random_word();
    tlfq_pkg::in_word_t w;
    int                 pick;
    int                 k;
    pick          = $urandom_range(99);
    k             = $urandom_range(POOL_SIZE - 1);
    w.interrupted = 1'($urandom_range(1));
    w.proc_id     = pid_pool[k];
    if (pick < 30) begin
      w.command = tlfq_pkg::CMD_ADMIT;
      if ($urandom_range(9) == 0) begin
        pid_pool[k] = fresh_pid();
        w.proc_id   = pid_pool[k];
      end
    end else if (pick < 60) begin
      w.command = tlfq_pkg::CMD_DISPATCH;
    end else if (pick < 93) begin
      w.command = ($urandom_range(3) == 0) ? tlfq_pkg::CMD_TERMINATE : tlfq_pkg::CMD_REQUEUE;
      if (sb.awaiting_report) w.proc_id = sb.running_pid;
    end else begin
      w.command = ($urandom_range(1) == 0) ? tlfq_pkg::CMD_TERMINATE : tlfq_pkg::CMD_REQUEUE;
      w.proc_id = fresh_pid();
    end
    return w;
  endfunction

  // Offers one command word and holds it until accepted, then returns at the
  // following falling edge, possibly after an idle gap.
  task issue(tlfq_pkg::cmd_t c, logic [tlfq_pkg::PID_W-1:0] p, logic i);
    tlfq_pkg::in_word_t w;
    w.command     = c;
    w.proc_id     = p;
    w.interrupted = i;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Writes the slot limit once the block is idle, after every result word has come back.
  task write_limit(logic [tlfq_pkg::CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.due_replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.slot_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task run_random(int items, int idle_pct, int stall);
    tlfq_pkg::in_word_t w;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (items) begin
      w = next_random_word();
      issue(w.command, w.proc_id, w.interrupted);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests = 0;
    sb = new();
    foreach (pid_pool[k]) pid_pool[k] = fresh_pid();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. A limit above sixteen must act as sixteen.
    write_limit(tlfq_pkg::CNT_W'(31));
    issue(tlfq_pkg::CMD_DISPATCH, tlfq_pkg::PID_W'(1), 1'b0);        // nothing queued yet
    issue(tlfq_pkg::CMD_ADMIT, tlfq_pkg::PID_W'(1), 1'b0);
    issue(tlfq_pkg::CMD_ADMIT, {tlfq_pkg::PID_W{1'b1}}, 1'b0);
    issue(tlfq_pkg::CMD_ADMIT, tlfq_pkg::PID_W'(1), 1'b0);           // same pid twice
    for (int i = 0; i < 13; i++)
      issue(tlfq_pkg::CMD_ADMIT, tlfq_pkg::PID_W'(100 + 7 * i), 1'b0);
    // All sixteen slots are taken and the top queue is full as well: the slot
    // check has to win.
    issue(tlfq_pkg::CMD_ADMIT, tlfq_pkg::PID_W'(77), 1'b0);
    // Both copies of pid 1 go, leaving two stale entries in the top queue.
    issue(tlfq_pkg::CMD_TERMINATE, tlfq_pkg::PID_W'(1), 1'b0);
    issue(tlfq_pkg::CMD_TERMINATE, tlfq_pkg::PID_W'(1), 1'b0);
    issue(tlfq_pkg::CMD_ADMIT, tlfq_pkg::PID_W'(77), 1'b0);          // slots free, queue full
    issue(tlfq_pkg::CMD_REQUEUE, {tlfq_pkg::PID_W{1'b1}}, 1'b1);     // requeue into a full queue
    issue(tlfq_pkg::CMD_DISPATCH, tlfq_pkg::PID_W'(1), 1'b0);        // stale entry
    issue(tlfq_pkg::CMD_DISPATCH, tlfq_pkg::PID_W'(1), 1'b0);        // picks the all-ones pid
    issue(tlfq_pkg::CMD_DISPATCH, tlfq_pkg::PID_W'(1), 1'b0);        // still outstanding
    issue(tlfq_pkg::CMD_DISPATCH, tlfq_pkg::PID_W'(1), 1'b0);        // still outstanding
    issue(tlfq_pkg::CMD_TERMINATE, tlfq_pkg::PID_W'(12345), 1'b0);   // pid not known
    issue(tlfq_pkg::CMD_REQUEUE, {tlfq_pkg::PID_W{1'b1}}, 1'b0);     // down to level 1
    issue(tlfq_pkg::CMD_REQUEUE, {tlfq_pkg::PID_W{1'b1}}, 1'b0);     // no dispatch outstanding
    issue(tlfq_pkg::CMD_REQUEUE, {tlfq_pkg::PID_W{1'b1}}, 1'b0);     // level saturates at 2
    // A limit of zero refuses every admit.
    write_limit('0);
    issue(tlfq_pkg::CMD_ADMIT, tlfq_pkg::PID_W'(55), 1'b0);

    // Random part, through several limits and idling patterns.
    write_limit(tlfq_pkg::CNT_W'(16));
    run_random(250, 0, 0);
    write_limit(tlfq_pkg::CNT_W'(1));
    run_random(200, 74, 0);
    write_limit(tlfq_pkg::CNT_W'(8));
    run_random(250, 0, 74);
    write_limit(tlfq_pkg::CNT_W'(16));
    run_random(250, 28, 28);
    // Long receiver hold-off while the sender keeps offering words.
    write_limit(tlfq_pkg::CNT_W'($urandom_range(16, 1)));
    hold_requests++;
    run_random(150, 0, 0);
    write_limit(tlfq_pkg::CNT_W'($urandom_range(16, 2)));
    run_random(300, 28, 28);

    in_valid <= 1'b0;
    while (sb.due_replies.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (sb.bad_replies == 0 && sb.due_replies.size() == 0) begin
      $display("three_level_feedback_queue_scheduler_unit: match");
    end else begin
      $display("three_level_feedback_queue_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
